// ===== rtl/sec_pkg.sv =====
// Shared types and constants for the RGB Sobel edge filter.
`timescale 1ns / 1ps
package sec_pkg;

	localparam int WIDTH_W    = 11;
	localparam int HEIGHT_W   = 13;
	localparam int ROW_W      = 12;
	localparam int MAX_HEIGHT = 4096;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 13;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

	localparam logic [WIDTH_W-1:0]  RESET_WIDTH  = 11'd640;
	localparam logic [HEIGHT_W-1:0] RESET_HEIGHT = 13'd480;

	localparam logic CMD_FLUSH = 1'b1;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;
	localparam int QCNT_W      = 3;

	typedef logic [23:0] pix_t;

	typedef struct packed {
		pix_t [8:0] win;
		logic       border;
		logic       last;
	} entry_t;

endpackage

// ===== rtl/sec_front.sv =====
// Front end: stream position tracking, row memory and 3x3 window.
`timescale 1ns / 1ps
module sec_front #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	input  logic [sec_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [sec_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           accept,
	input  logic                           command,
	input  logic [7:0]                     red_in,
	input  logic [7:0]                     green_in,
	input  logic [7:0]                     blue_in,
	output logic                           push_valid,
	output sec_pkg::entry_t                push_data
);
	import sec_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int XW = (WW > WIDTH_W) ? WW : WIDTH_W;

	logic [WIDTH_W-1:0]  width_q;
	logic [HEIGHT_W-1:0] height_q;
	logic [CW-1:0]       in_col_q, out_col_q;
	logic [ROW_W-1:0]    in_row_q, out_row_q;
	logic [WW-1:0]       pend_q;

	logic [XW-1:0]       wx;
	logic [WW-1:0]       eff_w;
	logic [HEIGHT_W-1:0] eff_h;
	logic [CW-1:0]       w_m1;
	logic [ROW_W-1:0]    h_m1;

	logic                frame_start, is_flush, clr, act, emit, border, last;
	logic [WW-1:0]       pend_base, pend_nx;
	logic [CW-1:0]       ocol_base, out_col_nx, in_col_nx, rd_col;
	logic [ROW_W-1:0]    orow_base, out_row_nx, in_row_nx;
	pix_t                pix;

	logic [47:0]         row_mem_q [MAX_WIDTH];
	logic [47:0]         rd_q;
	logic                s1_valid_q, s1_wr_q, s1_emit_q, s1_border_q, s1_last_q, s1_fwd_q;
	logic [CW-1:0]       s1_col_q;
	pix_t                s1_pix_q, fwd_top_q, fwd_mid_q, top, mid;
	pix_t [8:0]          win_q, win_nx;

	// effective frame size
	always_comb begin
		wx = XW'(width_q);
		if (wx == '0)
			eff_w = WW'(1);
		else if (wx > XW'(MAX_WIDTH))
			eff_w = WW'(MAX_WIDTH);
		else
			eff_w = WW'(wx);
		if (height_q == '0)
			eff_h = HEIGHT_W'(1);
		else if (height_q > HEIGHT_W'(MAX_HEIGHT))
			eff_h = HEIGHT_W'(MAX_HEIGHT);
		else
			eff_h = height_q;
		w_m1 = CW'(eff_w - WW'(1));
		h_m1 = ROW_W'(eff_h - HEIGHT_W'(1));
	end

	// classify the incoming word
	always_comb begin
		pix         = {red_in, green_in, blue_in};
		frame_start = (in_col_q == '0) && (in_row_q == '0);
		is_flush    = (command == CMD_FLUSH);
		clr         = !is_flush && frame_start && (pend_q != eff_w);
		pend_base   = clr ? '0 : pend_q;
		ocol_base   = clr ? '0 : out_col_q;
		orow_base   = clr ? '0 : out_row_q;
		act         = !is_flush || (frame_start && (pend_q != '0));
		emit        = is_flush ? act : (pend_base == eff_w);
		rd_col      = is_flush ? CW'(eff_w - pend_q) : in_col_q;
		border      = (orow_base == '0) || (orow_base == h_m1) ||
		              (ocol_base == '0) || (ocol_base == w_m1);
		last        = (orow_base == h_m1) && (ocol_base == w_m1);

		in_col_nx = in_col_q;
		in_row_nx = in_row_q;
		if (!is_flush) begin
			if (in_col_q == w_m1) begin
				in_col_nx = '0;
				in_row_nx = (in_row_q == h_m1) ? '0 : in_row_q + 1'b1;
			end else begin
				in_col_nx = in_col_q + 1'b1;
			end
		end

		if (!is_flush)
			pend_nx = emit ? pend_base : pend_base + 1'b1;
		else if (act)
			pend_nx = pend_q - 1'b1;
		else
			pend_nx = pend_q;

		out_col_nx = ocol_base;
		out_row_nx = orow_base;
		if (emit) begin
			if (ocol_base == w_m1) begin
				out_col_nx = '0;
				out_row_nx = (orow_base == h_m1) ? '0 : orow_base + 1'b1;
			end else begin
				out_col_nx = ocol_base + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q   <= RESET_WIDTH;
			height_q  <= RESET_HEIGHT;
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			pend_q    <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_IMAGE_WIDTH:  width_q  <= cfg_data[WIDTH_W-1:0];
				REG_IMAGE_HEIGHT: height_q <= cfg_data;
			endcase
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			pend_q    <= '0;
		end else if (accept) begin
			in_col_q  <= in_col_nx;
			in_row_q  <= in_row_nx;
			out_col_q <= out_col_nx;
			out_row_q <= out_row_nx;
			pend_q    <= pend_nx;
		end
	end

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			s1_valid_q <= 1'b0;
		else
			s1_valid_q <= accept && act;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			s1_wr_q     <= !is_flush;
			s1_emit_q   <= emit;
			s1_border_q <= border;
			s1_last_q   <= last;
			s1_col_q    <= rd_col;
			s1_pix_q    <= is_flush ? '0 : pix;
			// write of the word ahead lands on the same edge as this read
			s1_fwd_q    <= s1_valid_q && s1_wr_q && (s1_col_q == rd_col);
		end
	end

	always_comb begin
		top = s1_fwd_q ? fwd_top_q : rd_q[47:24];
		mid = s1_fwd_q ? fwd_mid_q : rd_q[23:0];
		win_nx[0] = win_q[1];
		win_nx[1] = win_q[2];
		win_nx[2] = top;
		win_nx[3] = win_q[4];
		win_nx[4] = win_q[5];
		win_nx[5] = mid;
		win_nx[6] = win_q[7];
		win_nx[7] = win_q[8];
		win_nx[8] = s1_pix_q;
	end

	// row memory: {older, newer} per column
	always_ff @(posedge clk) begin
		if (accept && act)
			rd_q <= row_mem_q[rd_col];
		if (s1_valid_q && s1_wr_q) begin
			row_mem_q[s1_col_q] <= {mid, s1_pix_q};
			fwd_top_q           <= mid;
			fwd_mid_q           <= s1_pix_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			win_q <= '0;
		else if (s1_valid_q)
			win_q <= win_nx;
	end

	assign push_valid       = s1_valid_q && s1_emit_q;
	assign push_data.win    = win_nx;
	assign push_data.border = s1_border_q;
	assign push_data.last   = s1_last_q;

	a_pend_range: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= eff_w) else $error("pending count above row width");
	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		in_col_q <= w_m1) else $error("input column out of range");

endmodule

// ===== rtl/sec_queue.sv =====
// Short queue of window snapshots between front and back.
`timescale 1ns / 1ps
module sec_queue (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push_valid,
	input  sec_pkg::entry_t            push_data,
	input  logic                       pop,
	output logic                       q_valid,
	output sec_pkg::entry_t            q_data,
	output logic [sec_pkg::QCNT_W-1:0] count
);
	import sec_pkg::*;

	entry_t            q_mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	always_ff @(posedge clk) begin
		if (push_valid)
			q_mem_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push_valid)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({push_valid, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	assign q_valid = (count_q != '0);
	assign q_data  = q_mem_q[rd_ptr_q];
	assign count   = count_q;

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push_valid && (count_q == QCNT_W'(QUEUE_DEPTH))))
		else $error("push into full queue");

endmodule

// ===== rtl/sec_back.sv =====
// Back end: Sobel gradients, clamp, saturating sum and output register; border pixels pass unfiltered.
`timescale 1ns / 1ps
module sec_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_valid,
	input  sec_pkg::entry_t q_data,
	output logic            q_pop,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [7:0]      red_out,
	output logic [7:0]      green_out,
	output logic [7:0]      blue_out,
	output logic            last_pixel
);
	import sec_pkg::*;

	function automatic logic [7:0] clamp_diff(input logic [9:0] p, input logic [9:0] n);
		logic [9:0] d;
		d = p - n;
		if (n >= p)
			return 8'd0;
		else if (d > 10'd255)
			return 8'hFF;
		else
			return d[7:0];
	endfunction

	// returns {gx, gy} for the channel at bit offset sh
	function automatic logic [15:0] grads(input pix_t [8:0] w, input logic [4:0] sh);
		logic [7:0] tl, tm, tr, ml, mr, bl, bm, br;
		logic [9:0] xp, xn, yp, yn;
		tl = w[0][sh +: 8];
		tm = w[1][sh +: 8];
		tr = w[2][sh +: 8];
		ml = w[3][sh +: 8];
		mr = w[5][sh +: 8];
		bl = w[6][sh +: 8];
		bm = w[7][sh +: 8];
		br = w[8][sh +: 8];
		xp = {2'b0, tr} + {1'b0, mr, 1'b0} + {2'b0, br};
		xn = {2'b0, tl} + {1'b0, ml, 1'b0} + {2'b0, bl};
		yp = {2'b0, tl} + {1'b0, tm, 1'b0} + {2'b0, tr};
		yn = {2'b0, bl} + {1'b0, bm, 1'b0} + {2'b0, br};
		return {clamp_diff(xp, xn), clamp_diff(yp, yn)};
	endfunction

	function automatic logic [7:0] sat_add(input logic [7:0] a, input logic [7:0] b);
		logic [8:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[8] ? 8'hFF : s[7:0];
	endfunction

	logic             valid_s1, valid_s2;
	logic [2:0][15:0] grad_s1;
	logic             border_s1, last_s1, last_s2;
	pix_t             center_s1, pix_s2, pix_nx;
	logic             s1_ready, s2_ready;

	assign s2_ready = !valid_s2 || out_ready;
	assign s1_ready = !valid_s1 || s2_ready;
	assign q_pop    = q_valid && s1_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s1_ready)
				valid_s1 <= q_valid;
			if (s2_ready)
				valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			grad_s1[0] <= grads(q_data.win, 5'd16);
			grad_s1[1] <= grads(q_data.win, 5'd8);
			grad_s1[2] <= grads(q_data.win, 5'd0);
			border_s1  <= q_data.border;
			last_s1    <= q_data.last;
			center_s1  <= q_data.win[4];
		end
	end

	always_comb begin
		if (border_s1)
			pix_nx = center_s1;
		else
			pix_nx = {sat_add(grad_s1[0][15:8], grad_s1[0][7:0]),
			          sat_add(grad_s1[1][15:8], grad_s1[1][7:0]),
			          sat_add(grad_s1[2][15:8], grad_s1[2][7:0])};
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && s2_ready) begin
			pix_s2  <= pix_nx;
			last_s2 <= last_s1;
		end
	end

	assign out_valid  = valid_s2;
	assign red_out    = pix_s2[23:16];
	assign green_out  = pix_s2[15:8];
	assign blue_out   = pix_s2[7:0];
	assign last_pixel = last_s2;

endmodule

// ===== rtl/sobel_edge_rgb_clamped.sv =====
// Top level of the streaming RGB Sobel edge filter with clamped gradients.
//
//  channel  direction  handshake              payload
//  in       sink       in_valid / in_ready    command, red_in, green_in, blue_in
//  out      source     out_valid / out_ready  red_out, green_out, blue_out, last_pixel
//  cfg      sink       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One word per clock sustained while out_ready holds high and the queue has room; a result
// is registered in front stage 1, then passes the queue write and the two arithmetic stages.
// The row memory is single write, single read, one access of each per cycle.
// Reset leaves the row memory unwritten; no clearing pass is needed.
// A four-word queue parts front and back; in_ready drops when the queue plus the
// word in flight would fill it. cfg_ready is always high.
`timescale 1ns / 1ps
module sobel_edge_rgb_clamped #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           command,
	input  logic [7:0]                     red_in,
	input  logic [7:0]                     green_in,
	input  logic [7:0]                     blue_in,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [7:0]                     red_out,
	output logic [7:0]                     green_out,
	output logic [7:0]                     blue_out,
	output logic                           last_pixel,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [sec_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [sec_pkg::CFG_DATA_W-1:0] cfg_data
);
	import sec_pkg::*;

	logic              push_valid, q_valid, q_pop, accept;
	entry_t            push_data, q_data;
	logic [QCNT_W-1:0] q_count;
	logic [QCNT_W:0]   credit;

	assign credit    = {1'b0, q_count} + {{QCNT_W{1'b0}}, push_valid};
	assign in_ready  = (credit < (QCNT_W + 1)'(QUEUE_DEPTH));
	assign accept    = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	sec_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.accept     (accept),
		.command    (command),
		.red_in     (red_in),
		.green_in   (green_in),
		.blue_in    (blue_in),
		.push_valid (push_valid),
		.push_data  (push_data)
	);

	sec_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_data  (push_data),
		.pop        (q_pop),
		.q_valid    (q_valid),
		.q_data     (q_data),
		.count      (q_count)
	);

	sec_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.q_data     (q_data),
		.q_pop      (q_pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.red_out    (red_out),
		.green_out  (green_out),
		.blue_out   (blue_out),
		.last_pixel (last_pixel)
	);

endmodule
